// ----- hw/rtl/ikht_pkg.sv -----
// shared constants, codes and types of the integer key hash table
`default_nettype none
package ikht_pkg;

	localparam int BUCKETS = 1024;
	localparam int NODES   = 1024;
	localparam int BKT_W   = $clog2(BUCKETS);
	localparam int NODE_W  = $clog2(NODES);
	localparam int LINK_W  = NODE_W + 1;
	localparam int MASK_W  = 10;
	localparam int CNT_W   = 11;
	localparam int STAT_W  = 32;
	localparam int KEY_W   = 32;
	localparam int DATA_W  = 32;
	localparam int OP_W    = 3;
	localparam int ST_W    = 2;

	localparam logic [LINK_W-1:0] NIL = LINK_W'(NODES);
	localparam logic [MASK_W-1:0] MASK_RESET = MASK_W'(1023);

	typedef enum logic [OP_W-1:0] {
		OP_LOOKUP  = 3'd0,
		OP_ADD     = 3'd1,
		OP_DELETE  = 3'd2,
		OP_REPLACE = 3'd3,
		OP_FLUSH   = 3'd4
	} op_t;

	localparam logic [ST_W-1:0] ST_OK      = 2'd0;
	localparam logic [ST_W-1:0] ST_MISSING = 2'd1;
	localparam logic [ST_W-1:0] ST_DUP     = 2'd2;
	localparam logic [ST_W-1:0] ST_FULL    = 2'd3;

	function automatic logic node_ok(input logic [LINK_W-1:0] n);
		return n < NIL;
	endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/ikht_if.sv -----
// request and response channel interfaces of the hash table
`default_nettype none
interface ikht_req_if;
	logic                              valid;
	logic                              ready;
	logic [ikht_pkg::OP_W-1:0]         operation;
	logic signed [ikht_pkg::KEY_W-1:0] key;
	logic [ikht_pkg::DATA_W-1:0]       data_value;
	modport source (output valid, operation, key, data_value, input ready);
	modport sink (input valid, operation, key, data_value, output ready);
endinterface

interface ikht_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [ikht_pkg::ST_W-1:0]    status;
	logic [ikht_pkg::DATA_W-1:0]  data_out;
	logic [ikht_pkg::CNT_W-1:0]   entry_count;
	logic [ikht_pkg::STAT_W-1:0]  delete_count;
	logic [ikht_pkg::CNT_W-1:0]   empty_buckets;
	logic [ikht_pkg::STAT_W-1:0]  scan_count;
	logic [ikht_pkg::STAT_W-1:0]  hit_count;
	logic [ikht_pkg::STAT_W-1:0]  check_count;
	logic [ikht_pkg::CNT_W-1:0]   longest_scan;
	modport source (output valid, status, data_out, entry_count, delete_count,
		empty_buckets, scan_count, hit_count, check_count, longest_scan, input ready);
	modport sink (input valid, status, data_out, entry_count, delete_count,
		empty_buckets, scan_count, hit_count, check_count, longest_scan, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/ikht_ram.sv -----
// simple dual port ram with registered read
`default_nettype none
module ikht_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  wire logic                       clk,
	input  wire logic                       we,
	input  wire logic [$clog2(DEPTH)-1:0]   waddr,
	input  wire logic [WIDTH-1:0]           wdata,
	input  wire logic [$clog2(DEPTH)-1:0]   raddr,
	output logic      [WIDTH-1:0]           rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

// ----- hw/rtl/integer_key_chained_hash_table.sv -----
// top level: chained hash table sequencer, node pool and statistics
`default_nettype none
// Hash table with 32-bit integer keys. The bucket is key AND bucket_mask; entries live
// in a pool of 1024 nodes chained per bucket, new entries at the chain head. One
// request is handled at a time over a walk through node memory with one read port.
// Lookup, add, delete and replace read and compare one chain node after another until
// the key is found or the chain ends; add then inserts a node when the key is missing,
// and delete unlinks the node it finds. Flush clears the bucket head memory one entry
// a cycle. After reset the same clearing pass runs before the first request is taken;
// bucket_mask may be written meanwhile.
module integer_key_chained_hash_table (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic [ikht_pkg::MASK_W-1:0] cfg_wdata,
	ikht_req_if.sink                         req,
	ikht_rsp_if.source                       rsp
);
	import ikht_pkg::*;

	typedef enum logic [10:0] {
		S_CLEAR  = 11'b000_0000_0001,
		S_IDLE   = 11'b000_0000_0010,
		S_HEAD   = 11'b000_0000_0100,
		S_LOAD   = 11'b000_0000_1000,
		S_RD     = 11'b000_0001_0000,
		S_CMP    = 11'b000_0010_0000,
		S_ALLOC  = 11'b000_0100_0000,
		S_ALLOC2 = 11'b000_1000_0000,
		S_DEL1   = 11'b001_0000_0000,
		S_DEL2   = 11'b010_0000_0000,
		S_DONE   = 11'b100_0000_0000
	} state_t;

	state_t              state_q;
	logic [BKT_W-1:0]    clr_q;
	logic                flush_q;
	logic [MASK_W-1:0]   mask_q;
	logic [OP_W-1:0]     op_q;
	logic [KEY_W-1:0]    key_q;
	logic [DATA_W-1:0]   val_q;
	logic [BKT_W-1:0]    bkt_q;
	logic [LINK_W-1:0]   hd_q;
	logic [LINK_W-1:0]   n_q;
	logic [LINK_W-1:0]   prev_q;
	logic [LINK_W-1:0]   nxt_q;
	logic [CNT_W-1:0]    chk_q;
	logic [LINK_W-1:0]   free_q;
	logic [LINK_W-1:0]   fresh_q;
	logic [ST_W-1:0]     st_q;
	logic [DATA_W-1:0]   dout_q;
	logic [CNT_W-1:0]    entries_q;
	logic [STAT_W-1:0]   deletes_q;
	logic [CNT_W-1:0]    empty_q;
	logic [STAT_W-1:0]   scans_q;
	logic [STAT_W-1:0]   hits_q;
	logic [STAT_W-1:0]   checks_q;
	logic [CNT_W-1:0]    max_q;

	// memory ports
	logic                head_we;
	logic [BKT_W-1:0]    head_wa;
	logic [LINK_W-1:0]   head_wd;
	logic [LINK_W-1:0]   head_rd;
	logic                link_we;
	logic [NODE_W-1:0]   link_wa;
	logic [LINK_W-1:0]   link_wd;
	logic [NODE_W-1:0]   link_ra;
	logic [LINK_W-1:0]   link_rd;
	logic                key_we;
	logic [KEY_W-1:0]    key_rd;
	logic                data_we;
	logic [DATA_W-1:0]   data_wd;
	logic [DATA_W-1:0]   data_rd;

	logic                hit;
	logic                chain_end;
	logic                counted;
	logic [CNT_W-1:0]    chk_nx;
	logic [BKT_W-1:0]    req_bkt;

	assign hit       = (key_rd == key_q);
	assign chain_end = !node_ok(n_q) || (chk_q == CNT_W'(NODES));
	assign counted   = (op_q == OP_LOOKUP) || (op_q == OP_ADD);
	assign chk_nx    = chk_q + CNT_W'(1);
	assign req_bkt   = BKT_W'(req.key[MASK_W-1:0] & mask_q);
	assign req.ready = (state_q == S_IDLE);

	always_comb begin
		head_we = 1'b0;
		head_wa = bkt_q;
		head_wd = NIL;
		link_we = 1'b0;
		link_wa = n_q[NODE_W-1:0];
		link_wd = free_q;
		link_ra = n_q[NODE_W-1:0];
		key_we  = 1'b0;
		data_we = 1'b0;
		data_wd = val_q;
		unique case (state_q)
			S_CLEAR: begin
				head_we = 1'b1;
				head_wa = clr_q;
			end
			S_CMP: begin
				data_we = hit && (op_q == OP_REPLACE);
			end
			S_ALLOC: begin
				link_ra = free_q[NODE_W-1:0];
			end
			S_ALLOC2: begin
				head_we = 1'b1;
				head_wd = free_q;
				link_we = 1'b1;
				link_wa = free_q[NODE_W-1:0];
				link_wd = hd_q;
				key_we  = 1'b1;
				data_we = 1'b1;
			end
			S_DEL1: begin
				// unlink from the predecessor or from the bucket head
				if (node_ok(prev_q)) begin
					link_we = 1'b1;
					link_wa = prev_q[NODE_W-1:0];
					link_wd = nxt_q;
				end else begin
					head_we = 1'b1;
					head_wd = nxt_q;
				end
			end
			S_DEL2: begin
				link_we = 1'b1;
			end
			default: begin
			end
		endcase
	end

	ikht_ram #(.WIDTH(LINK_W), .DEPTH(BUCKETS)) u_heads (
		.clk(clk), .we(head_we), .waddr(head_wa), .wdata(head_wd),
		.raddr(bkt_q), .rdata(head_rd)
	);

	ikht_ram #(.WIDTH(LINK_W), .DEPTH(NODES)) u_links (
		.clk(clk), .we(link_we), .waddr(link_wa), .wdata(link_wd),
		.raddr(link_ra), .rdata(link_rd)
	);

	ikht_ram #(.WIDTH(KEY_W), .DEPTH(NODES)) u_keys (
		.clk(clk), .we(key_we), .waddr(free_q[NODE_W-1:0]), .wdata(key_q),
		.raddr(n_q[NODE_W-1:0]), .rdata(key_rd)
	);

	ikht_ram #(.WIDTH(DATA_W), .DEPTH(NODES)) u_data (
		.clk(clk), .we(data_we),
		.waddr(state_q == S_ALLOC2 ? free_q[NODE_W-1:0] : n_q[NODE_W-1:0]),
		.wdata(data_wd), .raddr(n_q[NODE_W-1:0]), .rdata(data_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			clr_q     <= '0;
			flush_q   <= 1'b0;
			mask_q    <= MASK_RESET;
			free_q    <= '0;
			fresh_q   <= '0;
			entries_q <= '0;
			deletes_q <= '0;
			empty_q   <= CNT_W'(MASK_RESET) + CNT_W'(1);
			scans_q   <= '0;
			hits_q    <= '0;
			checks_q  <= '0;
			max_q     <= '0;
			rsp.valid <= 1'b0;
		end else begin
			if (cfg_we) begin
				mask_q <= cfg_wdata;
			end
			if (state_q == S_DONE && (!rsp.valid || rsp.ready)) begin
				rsp.valid <= 1'b1;
			end else if (rsp.valid && rsp.ready) begin
				rsp.valid <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + BKT_W'(1);
					if (clr_q == BKT_W'(BUCKETS - 1)) begin
						state_q <= flush_q ? S_DONE : S_IDLE;
					end
				end
				S_IDLE: begin
					if (req.valid) begin
						op_q  <= req.operation;
						key_q <= req.key;
						val_q <= req.data_value;
						bkt_q <= req_bkt;
						st_q  <= ST_OK;
						dout_q <= '0;
						if (req.operation == OP_FLUSH) begin
							clr_q     <= '0;
							flush_q   <= 1'b1;
							free_q    <= '0;
							fresh_q   <= '0;
							entries_q <= '0;
							deletes_q <= '0;
							scans_q   <= '0;
							hits_q    <= '0;
							checks_q  <= '0;
							max_q     <= '0;
							empty_q   <= CNT_W'(mask_q) + CNT_W'(1);
							state_q   <= S_CLEAR;
						end else if (req.operation < OP_FLUSH) begin
							state_q <= S_HEAD;
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				S_HEAD: begin
					state_q <= S_LOAD;
				end
				S_LOAD: begin
					hd_q   <= head_rd;
					n_q    <= head_rd;
					prev_q <= NIL;
					chk_q  <= '0;
					if (counted) begin
						scans_q <= scans_q + STAT_W'(1);
					end
					state_q <= S_RD;
				end
				S_RD: begin
					if (chain_end) begin
						if (counted) begin
							checks_q <= checks_q + STAT_W'(chk_q);
							if (chk_q > max_q) begin
								max_q <= chk_q;
							end
						end
						state_q <= S_DONE;
						if (op_q == OP_ADD) begin
							if (!node_ok(free_q)) begin
								st_q <= ST_FULL;
							end else begin
								state_q <= S_ALLOC;
							end
						end else begin
							st_q <= ST_MISSING;
						end
					end else begin
						state_q <= S_CMP;
					end
				end
				S_CMP: begin
					chk_q <= chk_nx;
					if (hit) begin
						if (counted) begin
							hits_q   <= hits_q + STAT_W'(1);
							checks_q <= checks_q + STAT_W'(chk_nx);
							if (chk_nx > max_q) begin
								max_q <= chk_nx;
							end
						end
						nxt_q   <= link_rd;
						state_q <= S_DONE;
						if (op_q == OP_LOOKUP) begin
							dout_q <= data_rd;
						end else if (op_q == OP_ADD) begin
							st_q <= ST_DUP;
						end else if (op_q == OP_DELETE) begin
							state_q <= S_DEL1;
						end
					end else begin
						prev_q  <= n_q;
						n_q     <= link_rd;
						state_q <= S_RD;
					end
				end
				S_ALLOC: begin
					state_q <= S_ALLOC2;
				end
				S_ALLOC2: begin
					// untouched nodes above fresh_q follow each other in index order
					if (free_q == fresh_q) begin
						free_q  <= free_q + LINK_W'(1);
						fresh_q <= fresh_q + LINK_W'(1);
					end else begin
						free_q <= link_rd;
					end
					entries_q <= entries_q + CNT_W'(1);
					if (!node_ok(hd_q)) begin
						empty_q <= empty_q - CNT_W'(1);
					end
					state_q <= S_DONE;
				end
				S_DEL1: begin
					if (!node_ok(prev_q) && !node_ok(nxt_q)) begin
						empty_q <= empty_q + CNT_W'(1);
					end
					state_q <= S_DEL2;
				end
				S_DEL2: begin
					free_q    <= n_q;
					deletes_q <= deletes_q + STAT_W'(1);
					entries_q <= entries_q - CNT_W'(1);
					state_q   <= S_DONE;
				end
				S_DONE: begin
					if (!rsp.valid || rsp.ready) begin
						flush_q   <= 1'b0;
						state_q   <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && (!rsp.valid || rsp.ready)) begin
			rsp.status        <= st_q;
			rsp.data_out      <= dout_q;
			rsp.entry_count   <= entries_q;
			rsp.delete_count  <= deletes_q;
			rsp.empty_buckets <= empty_q;
			rsp.scan_count    <= scans_q;
			rsp.hit_count     <= hits_q;
			rsp.check_count   <= checks_q;
			rsp.longest_scan  <= max_q;
		end
	end

`ifndef SYNTHESIS
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && req.valid) |=> (state_q != S_IDLE))
		else $error("request accepted but sequencer stayed idle");

	a_pool_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(!node_ok(free_q) && state_q != S_CLEAR) |-> (entries_q == CNT_W'(NODES)))
		else $error("free list empty with pool not fully used");

	a_result_issued: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && (!rsp.valid || rsp.ready)) |=> rsp.valid)
		else $error("finished request produced no response");
`endif

endmodule
`default_nettype wire
